[rtl/srrb_pkg.sv]
// Shared types and constants of the seeded shift-register random bit generator.
package srrb_pkg;

    localparam int unsigned GEN_W         = 32;
    localparam int unsigned TAP_IDX       = 17;
    localparam int unsigned LOW_SEED_BITS = 17;

    localparam logic [GEN_W-1:0] SEED_FIX = 32'd8815;
    localparam logic [GEN_W-1:0] STEP_SUB = 32'd19;

    localparam logic [1:0] ACT_LOAD   = 2'd0;
    localparam logic [1:0] ACT_REWIND = 2'd1;
    localparam logic [1:0] ACT_DRAW   = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DRAW,
        ST_DONE
    } srrb_state_t;

    typedef struct packed {
        logic [GEN_W-1:0] next_state;
        logic             out_bit;
    } srrb_step_t;

endpackage

[rtl/srrb_step.sv]
// One generator step: tap test on bit 17, then subtract-and-shift or plain shift.
module srrb_step
    import srrb_pkg::*;
(
    input  logic [GEN_W-1:0] cur_state,
    output srrb_step_t       step
);

    logic [GEN_W-1:0] minus_sub;

    assign minus_sub = cur_state - STEP_SUB;

    always_comb begin
        if (cur_state[TAP_IDX]) begin
            step.next_state = {minus_sub[GEN_W-2:0], 1'b1};
            step.out_bit    = 1'b1;
        end else begin
            step.next_state = {cur_state[GEN_W-2:0], 1'b0};
            step.out_bit    = 1'b0;
        end
    end

endmodule

[rtl/seeded_shift_register_random_bits.sv]
// Seeded shift-register random bit generator. One step unit advances the 32-bit generator
// state once per cycle under a small sequencer, and the block takes one item at a time.
// A load runs from accept through WARMUP_STEPS warm-up steps to handing over the beat;
// a draw of n bits runs n steps, with n saturated to MAX_DRAW_BITS; rewind, a zero-bit
// draw and the unused action code go from accept straight to handing over the beat. A
// finished result waits in the output register while the next item is accepted. The
// seed register is written through the cfg channel, which is always ready; the user must
// see that it is written only while idle, as the block itself does not enforce this.
module seeded_shift_register_random_bits
    import srrb_pkg::*;
#(
    parameter int unsigned WARMUP_STEPS  = 29,
    parameter int unsigned MAX_DRAW_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // action [1:0], bit_count [7:2]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // random_value [31:0], kept_seed_out [63:32]
);

    localparam int unsigned CNT_MAX =
        (WARMUP_STEPS > MAX_DRAW_BITS) ? WARMUP_STEPS : MAX_DRAW_BITS;
    localparam int unsigned CNT_W = $clog2(CNT_MAX + 1);

    srrb_state_t      state_reg, state_next;
    logic [GEN_W-1:0] gen_reg, gen_next;
    logic [GEN_W-1:0] kept_reg, kept_next;
    logic [GEN_W-1:0] seed_reg;
    logic [GEN_W-1:0] val_reg, val_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             m_tvalid_reg;
    logic [63:0]      m_tdata_reg;

    logic [1:0]       in_action;
    logic [5:0]       in_count;
    logic [5:0]       sat_count;
    logic [GEN_W-1:0] adj_seed;
    logic             in_accept;
    logic             out_free;
    logic             step_en;
    logic             out_load;
    srrb_step_t       step;

    assign in_action = s_tdata[1:0];
    assign in_count  = s_tdata[7:2];
    assign sat_count = (in_count > 6'(MAX_DRAW_BITS)) ? 6'(MAX_DRAW_BITS) : in_count;
    assign adj_seed  = (seed_reg[LOW_SEED_BITS-1:0] == '0) ? seed_reg + SEED_FIX : seed_reg;
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    srrb_step u_step (
        .cur_state (gen_reg),
        .step      (step)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    unique case (in_action)
                        ACT_LOAD:   state_next = (WARMUP_STEPS == 0) ? ST_DONE : ST_LOAD;
                        ACT_DRAW:   state_next = (sat_count == '0) ? ST_DONE : ST_DRAW;
                        default:    state_next = ST_DONE;
                    endcase
                end
            end
            ST_LOAD, ST_DRAW: begin
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_tready = 1'b0;
        step_en  = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:          s_tready = 1'b1;
            ST_LOAD, ST_DRAW: step_en  = 1'b1;
            ST_DONE:          out_load = out_free;
            default:          s_tready = 1'b0;
        endcase
    end

    // datapath
    always_comb begin
        gen_next  = gen_reg;
        kept_next = kept_reg;
        val_next  = val_reg;
        cnt_next  = cnt_reg;
        if (in_accept) begin
            val_next = '0;
            unique case (in_action)
                ACT_LOAD: begin
                    gen_next  = adj_seed;
                    kept_next = adj_seed;
                    cnt_next  = CNT_W'(WARMUP_STEPS);
                end
                ACT_REWIND: gen_next = kept_reg;
                ACT_DRAW:   cnt_next = CNT_W'(sat_count);
                default:    gen_next = gen_reg;
            endcase
        end else if (step_en) begin
            gen_next = step.next_state;
            cnt_next = cnt_reg - CNT_W'(1);
            if (state_reg == ST_DRAW) begin
                val_next = {val_reg[GEN_W-2:0], step.out_bit};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            gen_reg      <= SEED_FIX;
            kept_reg     <= SEED_FIX;
            seed_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            gen_reg   <= gen_next;
            kept_reg  <= kept_next;
            if (cfg_valid && cfg_ready) begin
                seed_reg <= cfg_data;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
        cnt_reg <= cnt_next;
        if (out_load) begin
            m_tdata_reg <= {kept_reg, val_reg};
        end
    end

`ifndef ASSERT_OFF
    a_step_cnt_live: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en |-> cnt_reg != '0)
        else $error("step issued with exhausted step count");

    a_load_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_tvalid)
        else $error("finished result not presented");

    a_done_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && m_tvalid && !m_tready) |=> state_reg == ST_DONE)
        else $error("result dropped while output stalled");

    a_rewind: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && in_action == ACT_REWIND) |=> gen_reg == $past(kept_reg))
        else $error("rewind did not restore kept seed");
`endif

endmodule

[tb/tb_top.sv]
// Testbench for the seeded shift-register random bit generator: stream drivers and a scoreboard.
`timescale 1ns / 1ps

import srrb_pkg::*;

localparam int unsigned WARMUP_RUN  = 29;
localparam int unsigned MAX_BITS    = 32;
localparam logic [1:0]  ACT_SPARE   = 2'd3;

class seed_gen_tracker;
    logic [31:0] seed_reg;
    logic [31:0] gen_state;
    logic [31:0] kept_seed;
    logic [63:0] owed_words[$];
    int unsigned mismatches;

    function new();
        seed_reg   = '0;
        gen_state  = SEED_FIX;
        kept_seed  = SEED_FIX;
        mismatches = 0;
    endfunction

    function void write_seed(logic [31:0] v);
        seed_reg = v;
    endfunction

    function logic advance();
        logic out_bit;
        out_bit = gen_state[TAP_IDX];
        if (out_bit) begin
            gen_state = ((gen_state - STEP_SUB) << 1) | 32'd1;
        end else begin
            gen_state = gen_state << 1;
        end
        return out_bit;
    endfunction

    function void take_command(logic [1:0] act, logic [5:0] cnt);
        logic [31:0] drawn;
        logic [31:0] s;
        int n;
        logic junk;
        drawn = '0;
        case (act)
            ACT_LOAD: begin
                s = seed_reg;
                // a seed with all low bits clear would lock the tap out, so nudge it
                if (s[LOW_SEED_BITS-1:0] == '0) begin
                    s = s + SEED_FIX;
                end
                kept_seed = s;
                gen_state = s;
                for (int i = 0; i < WARMUP_RUN; i++) begin
                    junk = advance();
                end
            end
            ACT_REWIND: begin
                gen_state = kept_seed;
            end
            ACT_DRAW: begin
                n = (cnt > MAX_BITS) ? MAX_BITS : cnt;
                // first bit lands in the top of the n places
                for (int i = n; i > 0; i--) begin
                    drawn[i-1] = advance();
                end
            end
            default: ;
        endcase
        owed_words.push_back({kept_seed, drawn});
    endfunction

    function void check_word(logic [63:0] word);
        logic [63:0] want;
        if (owed_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("unexpected beat: value=%h kept=%h", word[31:0], word[63:32]);
            end
            return;
        end
        want = owed_words.pop_front();
        if (word[31:0] !== want[31:0] || word[63:32] !== want[63:32]) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch: value exp=%h got=%h, kept exp=%h got=%h",
                         want[31:0], word[31:0], want[63:32], word[63:32]);
            end
        end
    endfunction

    function int pending();
        return owed_words.size();
    endfunction
endclass

module tb_top;

    localparam int QUIET_LIMIT = 4000;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // action [1:0], bit_count [7:2]
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // random_value [31:0], kept_seed_out [63:32]

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int quiet = 0;

    seed_gen_tracker tracker;

    seeded_shift_register_random_bits #(
        .WARMUP_STEPS (WARMUP_RUN),
        .MAX_DRAW_BITS(MAX_BITS)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        m_tready = ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                tracker.write_seed(cfg_data);
            end
            if (s_tvalid && s_tready) begin
                tracker.take_command(s_tdata[1:0], s_tdata[7:2]);
            end
            if (m_tvalid && m_tready) begin
                tracker.check_word(m_tdata);
            end
            if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet = 0;
            end else begin
                quiet = quiet + 1;
            end
        end
    end

    initial begin
        do @(posedge aclk); while (quiet < QUIET_LIMIT);
        $display("FAIL");
        $finish;
    end

    task automatic send_cmd(input logic [1:0] act, input logic [5:0] cnt);
        @(negedge aclk);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {cnt, act};
        do @(posedge aclk); while (!s_tready);
    endtask

    // hold off until every beat is back, then let the sequencer settle
    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (2) @(negedge aclk);
    endtask

    task automatic load_seed_reg(input logic [31:0] v);
        cfg_valid = 1'b1;
        cfg_data  = v;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_random_cmd();
        int roll;
        logic [1:0] act;
        logic [5:0] cnt;
        roll = $urandom_range(99);
        if (roll < 60) begin
            act = ACT_DRAW;
        end else if (roll < 72) begin
            act = ACT_LOAD;
        end else if (roll < 90) begin
            act = ACT_REWIND;
        end else begin
            act = ACT_SPARE;
        end
        if ($urandom_range(99) < 80) begin
            cnt = 6'($urandom_range(MAX_BITS));
        end else begin
            cnt = 6'($urandom_range(63, MAX_BITS + 1));
        end
        send_cmd(act, cnt);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int count,
                             input logic [31:0] first_seed);
        drain();
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        load_seed_reg(first_seed);
        send_cmd(ACT_LOAD, 6'($urandom_range(63)));
        for (int k = 1; k < count; k++) begin
            if (k == count / 2) begin
                drain();
                load_seed_reg($urandom);
            end
            send_random_cmd();
        end
    endtask

    initial begin
        tracker   = new();
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // straight from reset: draws on the reset state, then a load with a zero seed
        send_cmd(ACT_DRAW, 6'd32);
        send_cmd(ACT_DRAW, 6'd0);
        send_cmd(ACT_REWIND, 6'd0);
        send_cmd(ACT_DRAW, 6'd33);
        send_cmd(ACT_SPARE, 6'd63);
        send_cmd(ACT_LOAD, 6'd0);
        send_cmd(ACT_DRAW, 6'd1);
        send_cmd(ACT_DRAW, 6'd31);
        send_cmd(ACT_DRAW, 6'd63);

        drain();
        load_seed_reg(32'hFFFF_FFFF);
        send_cmd(ACT_LOAD, 6'd63);
        send_cmd(ACT_DRAW, 6'd32);
        send_cmd(ACT_DRAW, 6'd17);
        send_cmd(ACT_REWIND, 6'd63);
        send_cmd(ACT_DRAW, 6'd32);

        // low bits all clear: the load must fold in the fix-up
        drain();
        load_seed_reg(32'h0002_0000);
        send_cmd(ACT_LOAD, 6'd42);
        send_cmd(ACT_DRAW, 6'd32);
        send_cmd(ACT_SPARE, 6'd0);
        send_cmd(ACT_DRAW, 6'd32);
        send_cmd(ACT_REWIND, 6'd21);
        send_cmd(ACT_DRAW, 6'd48);

        run_phase(0, 0, 138, $urandom);
        run_phase(82, 0, 138, 32'hFFFE_0000);
        run_phase(0, 82, 138, $urandom);
        run_phase(23, 23, 138, 32'h0001_FFFF);

        @(negedge aclk);
        s_tvalid = 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
